// ===== hw/rtl/lbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_pkg
// shared types and constants for the lamp debounce and blink control block
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int NUM_SWITCHES = 5;
    localparam int NUM_LAMPS    = 4;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 1;

    // switch bit positions
    localparam int SW_LEFT  = 0;
    localparam int SW_RIGHT = 1;
    localparam int SW_FRONT = 2;
    localparam int SW_REAR  = 3;
    localparam int SW_HIGH  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLINK_HALF_PERIOD = 1'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST     = 16'd50;
    localparam logic [CFG_W-1:0] BLINK_HALF_PERIOD_RST = 16'd500;

    typedef struct packed {
        logic [TIME_W-1:0] now_time;
        logic              raw_left_switch;
        logic              raw_right_switch;
        logic              raw_front_brake;
        logic              raw_rear_brake;
        logic              raw_high_beam;
        logic              cmd_left_indicator;
        logic              cmd_right_indicator;
        logic              cmd_brake_bright;
        logic              cmd_high_beam;
    } lbc_in_t;

    typedef struct packed {
        logic left_lamp;
        logic right_lamp;
        logic brake_lamp;
        logic high_beam_lamp;
        logic lamps_changed;
    } lbc_out_t;

    // per-tick control handed to the state units
    typedef struct packed {
        logic step;   // tick is processed this cycle
        logic first;  // first tick since reset
    } lbc_ctl_t;

endpackage : lbc_pkg
`default_nettype wire

// ===== hw/rtl/lbc_debounce.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_debounce
// per-switch timestamp debounce, five switches in parallel
// ----------------------------------------------------------------------------
module lbc_debounce
    import lbc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lbc_ctl_t                ctl,
    input  wire logic [TIME_W-1:0]       now_time,
    input  wire logic [NUM_SWITCHES-1:0] raw,
    input  wire logic [CFG_W-1:0]        debounce_time,
    output logic      [NUM_SWITCHES-1:0] stable_next
);

    logic [NUM_SWITCHES-1:0] last_raw_reg;
    logic [NUM_SWITCHES-1:0] stable_reg;
    logic [TIME_W-1:0]       change_time_reg  [NUM_SWITCHES];
    logic [TIME_W-1:0]       change_time_next [NUM_SWITCHES];
    logic [TIME_W-1:0]       elapsed          [NUM_SWITCHES];

    always_comb
    begin
        for (int i = 0; i < NUM_SWITCHES; i++)
        begin
            // a new raw level restarts that switch's timer
            change_time_next[i] = (ctl.first || (raw[i] != last_raw_reg[i]))
                                  ? now_time : change_time_reg[i];
            elapsed[i] = now_time - change_time_next[i];
            if (ctl.first)
            begin
                stable_next[i] = raw[i];
            end
            else if ((stable_reg[i] != raw[i]) &&
                     (elapsed[i] >= {{(TIME_W-CFG_W){1'b0}}, debounce_time}))
            begin
                stable_next[i] = raw[i];
            end
            else
            begin
                stable_next[i] = stable_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_raw_reg <= '0;
            stable_reg   <= '0;
            for (int i = 0; i < NUM_SWITCHES; i++)
            begin
                change_time_reg[i] <= '0;
            end
        end
        else if (ctl.step)
        begin
            last_raw_reg <= raw;
            stable_reg   <= stable_next;
            for (int i = 0; i < NUM_SWITCHES; i++)
            begin
                change_time_reg[i] <= change_time_next[i];
            end
        end
    end

endmodule : lbc_debounce
`default_nettype wire

// ===== hw/rtl/lbc_lamp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_lamp
// indicator blink phase, lamp merge and change detect
// ----------------------------------------------------------------------------
module lbc_lamp
    import lbc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lbc_ctl_t                ctl,
    input  wire logic [TIME_W-1:0]       now_time,
    input  wire logic [NUM_SWITCHES-1:0] stable,
    input  wire logic [NUM_LAMPS-1:0]    cmd,
    input  wire logic [CFG_W-1:0]        blink_half_period,
    output lbc_out_t                     result
);

    logic                 phase_reg,   phase_next;
    logic [TIME_W-1:0]    toggle_reg,  toggle_next;
    logic                 was_active_reg;
    logic [NUM_LAMPS-1:0] lamps_reg,   lamps_next;

    logic              active;
    logic              was_active;
    logic              phase_base;
    logic [TIME_W-1:0] toggle_base;
    logic [TIME_W-1:0] since_toggle;

    always_comb
    begin
        active = stable[SW_LEFT] | stable[SW_RIGHT];
        // first tick is never an activation edge
        was_active   = ctl.first ? active   : was_active_reg;
        phase_base   = ctl.first ? 1'b1     : phase_reg;
        toggle_base  = ctl.first ? now_time : toggle_reg;
        since_toggle = now_time - toggle_base;

        phase_next  = phase_base;
        toggle_next = toggle_base;
        if (!active || !was_active)
        begin
            phase_next  = 1'b1;
            toggle_next = now_time;
        end
        else if (since_toggle >= {{(TIME_W-CFG_W){1'b0}}, blink_half_period})
        begin
            phase_next  = ~phase_base;
            toggle_next = now_time;
        end

        lamps_next[0] = stable[SW_LEFT]  ? phase_next : cmd[0];
        lamps_next[1] = stable[SW_RIGHT] ? phase_next : cmd[1];
        lamps_next[2] = stable[SW_FRONT] | stable[SW_REAR] | cmd[2];
        lamps_next[3] = stable[SW_HIGH] | cmd[3];

        result.left_lamp      = lamps_next[0];
        result.right_lamp     = lamps_next[1];
        result.brake_lamp     = lamps_next[2];
        result.high_beam_lamp = lamps_next[3];
        result.lamps_changed  = (lamps_next != lamps_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 1'b1;
            toggle_reg     <= '0;
            was_active_reg <= 1'b0;
            lamps_reg      <= '0;
        end
        else if (ctl.step)
        begin
            phase_reg      <= phase_next;
            toggle_reg     <= toggle_next;
            was_active_reg <= active;
            lamps_reg      <= lamps_next;
        end
    end

endmodule : lbc_lamp
`default_nettype wire

// ===== hw/rtl/lamp_debounce_blink_control.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lamp_debounce_blink_control
// debounced switch inputs, indicator flasher and lamp drive with change flag
// ----------------------------------------------------------------------------
// usage
//   in channel  : one beat per service tick (timestamp, raw switches, commands)
//   out channel : one beat per tick with the four lamp levels and a change flag
//   cfg port    : cfg_we/cfg_index/cfg_data, index 0 debounce time (ms),
//                 index 1 blink half period (ms); write only while idle
// timing
//   an input beat is captured in the input register, processed in one pass
//   of combinational logic into the result register: out_valid rises when
//   the result register is loaded; that waits while a held beat sees out_ready low
//   throughput one beat per cycle while out_ready stays high; the critical
//   path is the five debounce timer subtracts and compares feeding the
//   blink phase and lamp muxes
// reset
//   async active low; lamps off, blink phase on, debounce state cleared,
//   the next tick after reset loads the raw switch levels directly
// back-pressure
//   while out_ready is low the result register holds its beat and the input
//   register can still take one more beat; further beats wait on in_ready
// ----------------------------------------------------------------------------
module lamp_debounce_blink_control
    import lbc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lbc_in_t              in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lbc_out_t                  out_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // configuration registers
    logic [CFG_W-1:0] debounce_time_reg;
    logic [CFG_W-1:0] half_period_reg;

    // input register stage
    lbc_in_t in_data_reg;
    logic    in_valid_reg;

    // result register stage
    lbc_out_t out_data_reg;
    logic     out_valid_reg;

    // clear until the first tick has been processed
    logic     started_reg;

    lbc_ctl_t                ctl;
    logic [NUM_SWITCHES-1:0] raw;
    logic [NUM_SWITCHES-1:0] stable_next;
    logic [NUM_LAMPS-1:0]    cmd;
    lbc_out_t                result;

    // the tick in the input register moves on when the result slot frees up
    assign ctl.step  = in_valid_reg && (!out_valid_reg || out_ready);
    assign ctl.first = !started_reg;

    assign in_ready  = !in_valid_reg || ctl.step;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign raw = {in_data_reg.raw_high_beam, in_data_reg.raw_rear_brake,
                  in_data_reg.raw_front_brake, in_data_reg.raw_right_switch,
                  in_data_reg.raw_left_switch};
    assign cmd = {in_data_reg.cmd_high_beam, in_data_reg.cmd_brake_bright,
                  in_data_reg.cmd_right_indicator, in_data_reg.cmd_left_indicator};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_time_reg <= DEBOUNCE_TIME_RST;
            half_period_reg   <= BLINK_HALF_PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE_TIME:     debounce_time_reg <= cfg_data;
                REG_BLINK_HALF_PERIOD: half_period_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // result register and first-tick flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.step)
            begin
                out_valid_reg <= 1'b1;
                started_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            out_data_reg <= result;
        end
    end

    lbc_debounce u_debounce (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .now_time      (in_data_reg.now_time),
        .raw           (raw),
        .debounce_time (debounce_time_reg),
        .stable_next   (stable_next)
    );

    lbc_lamp u_lamp (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctl               (ctl),
        .now_time          (in_data_reg.now_time),
        .stable            (stable_next),
        .cmd               (cmd),
        .blink_half_period (half_period_reg),
        .result            (result)
    );

endmodule : lamp_debounce_blink_control
`default_nettype wire

// ===== hw/rtl/lbc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lbc_checker
// port level checks for the lamp debounce and blink control block
// ----------------------------------------------------------------------------
module lbc_checker
    import lbc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_ready,
    input  wire logic     out_valid,
    input  wire logic     out_ready,
    input  wire lbc_out_t out_data
);

    logic [NUM_LAMPS-1:0] seen_lamps_reg;
    logic [NUM_LAMPS-1:0] beat_lamps;

    assign beat_lamps = {out_data.high_beam_lamp, out_data.brake_lamp,
                         out_data.right_lamp, out_data.left_lamp};

    // lamp levels of the last delivered beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_lamps_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            seen_lamps_reg <= beat_lamps;
        end
    end

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // with an empty result slot the block always takes input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

    // change flag matches the lamp levels against the previous beat
    a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.lamps_changed == (beat_lamps != seen_lamps_reg)))
        else $error("lamps_changed disagrees with lamp history");

endmodule : lbc_checker

bind lamp_debounce_blink_control lbc_checker u_lbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

// ===== bench/tb_lamp_debounce_blink_control.sv =====
// ----------------------------------------------------------------------------
// tb_lamp_debounce_blink_control
// self-checking bench for the lamp debounce and blink control block: a short
// table of hand-made ticks, then random switch and command traffic under
// several debounce and blink settings, every lamp beat checked against an
// in-bench prediction of debounce, flasher and lamp drive behavior, or against
// the lamps typed into its table row
module tb_lamp_debounce_blink_control;
    timeunit 1ns;
    timeprecision 1ps;

    import lbc_pkg::*;

    // kind of row in the directed table
    typedef enum logic
    {
        ROW_TICK,
        ROW_CFG
    } row_kind_t;

    typedef struct
    {
        row_kind_t              kind;
        lbc_in_t                beat;
        bit                     typed;    // expected lamps written into the row
        lbc_out_t               want;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       val;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    lbc_in_t              in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    lbc_out_t             out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE_TIME;
    logic [CFG_W-1:0]     cfg_data = '0;

    always #2 clk = ~clk;

    lamp_debounce_blink_control DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // predicted block state, kept in step with every accepted input beat
    // ------------------------------------------------------------------------
    logic                    started_seen = 1'b0;
    logic [NUM_SWITCHES-1:0] sw_raw_seen = '0;
    logic [NUM_SWITCHES-1:0] sw_stable = '0;
    logic [TIME_W-1:0]       sw_edge_ms [NUM_SWITCHES] = '{default: '0};
    logic                    flash_on = 1'b1;
    logic [TIME_W-1:0]       flash_mark_ms = '0;
    logic                    ind_prev_active = 1'b0;
    logic [NUM_LAMPS-1:0]    lamps_prev = '0;
    logic [CFG_W-1:0]        settle_ms = DEBOUNCE_TIME_RST;
    logic [CFG_W-1:0]        half_period_ms = BLINK_HALF_PERIOD_RST;

    // lamp beats owed by the block, oldest first
    lbc_out_t lamps_due [$];

    // per-beat side info riding along with in_data
    bit        row_typed = 1'b0;
    lbc_out_t  row_want = '0;

    plan_row_t plan_rows [$];

    // idle mix and back-pressure control
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    bit          hold_req = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned ticks_taken = 0;
    int unsigned beats_checked = 0;
    int unsigned lamp_changes = 0;
    int unsigned reg_writes = 0;

    // ------------------------------------------------------------------------
    // predictor: debounce each switch by timestamp, run the flasher, then
    // mix local and commanded lamp requests
    // ------------------------------------------------------------------------
    function automatic lbc_out_t predict_lamps(lbc_in_t b);
        logic [NUM_SWITCHES-1:0] sw;
        logic [TIME_W-1:0]       t;
        logic [TIME_W-1:0]       gap;
        logic                    any_ind;
        logic [NUM_LAMPS-1:0]    nxt;
        lbc_out_t                r;
        t = b.now_time;
        sw[SW_LEFT]  = b.raw_left_switch;
        sw[SW_RIGHT] = b.raw_right_switch;
        sw[SW_FRONT] = b.raw_front_brake;
        sw[SW_REAR]  = b.raw_rear_brake;
        sw[SW_HIGH]  = b.raw_high_beam;
        if (!started_seen)
        begin
            // first tick after reset takes the raw levels as they are
            sw_raw_seen = sw;
            sw_stable   = sw;
            for (int i = 0; i < NUM_SWITCHES; i++)
                sw_edge_ms[i] = t;
        end
        else
        begin
            for (int i = 0; i < NUM_SWITCHES; i++)
            begin
                if (sw[i] != sw_raw_seen[i])
                begin
                    sw_raw_seen[i] = sw[i];
                    sw_edge_ms[i]  = t;
                end
                // elapsed time wraps modulo 2^32
                gap = t - sw_edge_ms[i];
                if (sw_stable[i] != sw_raw_seen[i] && gap >= {16'd0, settle_ms})
                    sw_stable[i] = sw_raw_seen[i];
            end
        end
        any_ind = sw_stable[SW_LEFT] | sw_stable[SW_RIGHT];
        if (!started_seen)
        begin
            flash_mark_ms   = t;
            flash_on        = 1'b1;
            ind_prev_active = any_ind;
            started_seen    = 1'b1;
        end
        gap = t - flash_mark_ms;
        if (any_ind && !ind_prev_active)
        begin
            flash_on      = 1'b1;
            flash_mark_ms = t;
        end
        else if (any_ind && gap >= {16'd0, half_period_ms})
        begin
            flash_on      = ~flash_on;
            flash_mark_ms = t;
        end
        if (!any_ind)
        begin
            flash_on      = 1'b1;
            flash_mark_ms = t;
        end
        ind_prev_active = any_ind;
        r.left_lamp      = sw_stable[SW_LEFT]  ? flash_on : b.cmd_left_indicator;
        r.right_lamp     = sw_stable[SW_RIGHT] ? flash_on : b.cmd_right_indicator;
        r.brake_lamp     = sw_stable[SW_FRONT] | sw_stable[SW_REAR] | b.cmd_brake_bright;
        r.high_beam_lamp = sw_stable[SW_HIGH] | b.cmd_high_beam;
        nxt = {r.high_beam_lamp, r.brake_lamp, r.right_lamp, r.left_lamp};
        r.lamps_changed = (nxt != lamps_prev);
        lamps_prev = nxt;
        return r;
    endfunction

    task automatic check_lamp(string fname, logic want, logic got);
        if (got !== want)
        begin
            $display("%0t: lamp beat %0d field %s expected %0b actual %0b",
                     $time, beats_checked, fname, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // monitor: both channels sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        lbc_out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = predict_lamps(in_data);
                // hand-typed rows override the prediction
                if (row_typed)
                    want = row_want;
                lamps_due.push_back(want);
                ticks_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (lamps_due.size() == 0)
                begin
                    $display("%0t: lamp beat with nothing expected, actual %b",
                             $time, out_data);
                    mismatch_count++;
                end
                else
                begin
                    want = lamps_due.pop_front();
                    check_lamp("left_lamp", want.left_lamp, out_data.left_lamp);
                    check_lamp("right_lamp", want.right_lamp, out_data.right_lamp);
                    check_lamp("brake_lamp", want.brake_lamp, out_data.brake_lamp);
                    check_lamp("high_beam_lamp", want.high_beam_lamp,
                               out_data.high_beam_lamp);
                    check_lamp("lamps_changed", want.lamps_changed,
                               out_data.lamps_changed);
                    if (want.lamps_changed)
                        lamp_changes++;
                    beats_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // sender side; every clocked task is entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_tick(lbc_in_t b, bit typed, lbc_out_t want);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        in_data   = b;
        row_typed = typed;
        row_want  = want;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // wait out every owed beat, then the pipeline latency
    task automatic drain_results();
        in_valid = 1'b0;
        while (lamps_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain_results();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_DEBOUNCE_TIME)
            settle_ms = val;
        else if (idx == REG_BLINK_HALF_PERIOD)
            half_period_ms = val;
        reg_writes++;
    endtask

    // sw order: left right front rear high; cmd order: left right brake high
    task automatic add_tick(logic [TIME_W-1:0] t, logic [4:0] sw, logic [3:0] cmd,
                            bit typed, lbc_out_t want);
        plan_row_t r;
        r.kind  = ROW_TICK;
        r.beat  = {t, sw, cmd};
        r.typed = typed;
        r.want  = want;
        r.idx   = REG_DEBOUNCE_TIME;
        r.val   = '0;
        plan_rows.push_back(r);
    endtask

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        plan_row_t r;
        r.kind  = ROW_CFG;
        r.beat  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        r.idx   = idx;
        r.val   = val;
        plan_rows.push_back(r);
    endtask

    // register setting mix with the extremes well represented
    function automatic logic [CFG_W-1:0] pick_ms();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4:    return CFG_W'($urandom_range(2, 20));
            5, 6:    return CFG_W'($urandom_range(20, 200));
            7:       return CFG_W'($urandom_range(200, 2000));
            default: return CFG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------------
    initial
    begin
        #2_000_000;
        $display("%0t: run limit reached, %0d lamp beats still owed", $time,
                 lamps_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main
        logic [TIME_W-1:0] t_now;
        logic [4:0]        sw_lvl;
        logic [3:0]        cmd_lvl;
        int unsigned       span;
        int unsigned       pick;
        lbc_in_t           beat;

        // directed table, reset settings: debounce 50 ms, half period 500 ms
        // first tick after reset: everything off, no change
        add_tick(32'd1000, 5'b00000, 4'b0000, 1'b1, 5'b00000);
        // commands alone drive all four lamps
        add_tick(32'd1010, 5'b00000, 4'b1111, 1'b1, 5'b11111);
        add_tick(32'd1011, 5'b00000, 4'b1111, 1'b1, 5'b11110);
        // left switch pressed, not yet debounced
        add_tick(32'd1020, 5'b10000, 4'b0000, 1'b1, 5'b00001);
        add_tick(32'd1069, 5'b10000, 4'b0000, 1'b1, 5'b00000);
        // held 50 ms: indicator activates in the on phase
        add_tick(32'd1070, 5'b10000, 4'b0000, 1'b1, 5'b10001);
        add_tick(32'd1569, 5'b10000, 4'b0000, 1'b1, 5'b10000);
        // half period elapsed: phase goes off
        add_tick(32'd1570, 5'b10000, 4'b0000, 1'b1, 5'b00001);
        // local indicator wins over the command
        add_tick(32'd1575, 5'b10000, 4'b1000, 1'b1, 5'b00000);
        add_tick(32'd2070, 5'b10000, 4'b0000, 1'b1, 5'b10001);
        // remaining switches, then a bounce that restarts their timers
        add_tick(32'd2080, 5'b11111, 4'b0000, 1'b0, '0);
        add_tick(32'd2130, 5'b11111, 4'b0000, 1'b0, '0);
        add_tick(32'd2131, 5'b01110, 4'b0101, 1'b0, '0);
        add_tick(32'd2135, 5'b11111, 4'b0000, 1'b0, '0);
        // zero debounce and zero half period
        add_cfg(REG_DEBOUNCE_TIME, 16'd0);
        add_cfg(REG_BLINK_HALF_PERIOD, 16'd0);
        add_tick(32'd2136, 5'b00000, 4'b0000, 1'b0, '0);
        add_tick(32'd2136, 5'b01000, 4'b0000, 1'b0, '0);
        add_tick(32'd2136, 5'b01000, 4'b0000, 1'b0, '0);
        add_tick(32'd2136, 5'b01000, 4'b0110, 1'b0, '0);
        // widest settings, backwards jump and wrap of the timestamp
        add_cfg(REG_DEBOUNCE_TIME, 16'hFFFF);
        add_cfg(REG_BLINK_HALF_PERIOD, 16'hFFFF);
        add_tick(32'hFFFF_FFFF, 5'b11111, 4'b1111, 1'b0, '0);
        add_tick(32'h0000_0005, 5'b11111, 4'b1111, 1'b0, '0);
        add_tick(32'h0001_0004, 5'b00000, 4'b0000, 1'b0, '0);
        add_tick(32'h8000_0000, 5'b00000, 4'b0000, 1'b0, '0);

        // reset once, released at a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        src_idle_pct  = 27;
        sink_idle_pct = 76;
        foreach (plan_rows[k])
        begin
            if (plan_rows[k].kind == ROW_CFG)
                write_reg(plan_rows[k].idx, plan_rows[k].val);
            else
                send_tick(plan_rows[k].beat, plan_rows[k].typed, plan_rows[k].want);
        end

        // random part: three idle mixes, four register settings each
        t_now   = 32'h0001_0004;
        sw_lvl  = '0;
        cmd_lvl = '0;
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct  = 27;
                    sink_idle_pct = 76;
                end
                1:
                begin
                    src_idle_pct  = 76;
                    sink_idle_pct = 27;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                // the sender pauses here until every owed beat has come
                if (seg == 0 && ph == 1)
                begin
                    write_reg(REG_DEBOUNCE_TIME, 16'd0);
                    write_reg(REG_BLINK_HALF_PERIOD, 16'hFFFF);
                end
                else if (seg == 0 && ph == 2)
                begin
                    write_reg(REG_DEBOUNCE_TIME, 16'hFFFF);
                    write_reg(REG_BLINK_HALF_PERIOD, 16'd0);
                end
                else
                begin
                    write_reg(REG_DEBOUNCE_TIME, pick_ms());
                    write_reg(REG_BLINK_HALF_PERIOD, pick_ms());
                end
                // long receiver hold-off while ticks keep coming
                if (ph == 0 && seg == 1)
                    hold_req = 1'b1;
                // time steps scaled to the settings so switches settle and blink
                span = ((settle_ms > half_period_ms ? settle_ms : half_period_ms) >> 3)
                       + 3;
                for (int n = 0; n < 155; n++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        t_now = $urandom();
                    else if (pick < 15)
                        t_now = t_now + $urandom_range(0, 70000);
                    else if (pick >= 20)
                        t_now = t_now + $urandom_range(1, span);
                    pick = $urandom_range(99);
                    if (pick < 10)
                        sw_lvl[$urandom_range(4)] ^= 1'b1;
                    else if (pick < 13)
                        sw_lvl = 5'($urandom());
                    if ($urandom_range(3) == 0)
                        cmd_lvl = 4'($urandom());
                    beat = {t_now, sw_lvl, cmd_lvl};
                    send_tick(beat, 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d ticks under %0d register writes", ticks_taken, reg_writes);
        $display("compared %0d lamp beats, %0d of them flagged a lamp change",
                 beats_checked, lamp_changes);
        if (mismatch_count == 0 && lamps_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/lbc_pkg.sv
hw/rtl/lbc_debounce.sv
hw/rtl/lbc_lamp.sv
hw/rtl/lamp_debounce_blink_control.sv
hw/rtl/lbc_checker.sv
bench/tb_lamp_debounce_blink_control.sv
